// ----- rtl/aes_pkg.sv -----
// shared types and constants for the advantage estimation step core
package aes_pkg;

  localparam int ENV_W      = 6;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 17;
  localparam int COEF_FRAC  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = 2;

  localparam logic [COEF_W-1:0] COEF_ONE          = 17'd65536;
  localparam logic [COEF_W-1:0] DISCOUNT_RESET    = 17'd64881;
  localparam logic [COEF_W-1:0] TRACE_DECAY_RESET = 17'd62259;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISCOUNT    = 1'b0,
    CFG_TRACE_DECAY = 1'b1
  } cfg_idx_e;

  // one sample with its classification flags
  typedef struct packed {
    logic [ENV_W-1:0]         env;
    logic signed [DATA_W-1:0] reward;
    logic signed [DATA_W-1:0] state_value;
    logic signed [DATA_W-1:0] bootstrap_value;
    logic                     done;
    logic                     first;
    logic                     in_range;
    logic                     needs_read;
  } aes_item_t;

endpackage

// ----- rtl/aes_front.sv -----
// input stage: takes samples and classifies them for the back end
module aes_front import aes_pkg::*; #(
  parameter int ENVS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ENV_W-1:0]         env_i,
  input  logic signed [DATA_W-1:0] reward_i,
  input  logic signed [DATA_W-1:0] state_value_i,
  input  logic                     done_i,
  input  logic                     first_i,
  input  logic signed [DATA_W-1:0] bootstrap_value_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output aes_item_t                push_item_o
);

  logic      valid_q, valid_d;
  aes_item_t item_q, item_d;
  logic      in_range;

  assign in_range   = 32'(env_i) < 32'(ENVS);
  assign in_ready_o = !valid_q || push_ready_i;

  always_comb begin
    item_d.env             = env_i;
    item_d.reward          = reward_i;
    item_d.state_value     = state_value_i;
    item_d.bootstrap_value = bootstrap_value_i;
    item_d.done            = done_i;
    item_d.first           = first_i;
    item_d.in_range        = in_range;
    item_d.needs_read      = in_range && !first_i && !done_i;
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

// ----- rtl/aes_queue.sv -----
// short item queue between the front and the back end
module aes_queue import aes_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  aes_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_i,
  output aes_item_t pop_item_o
);

  aes_item_t          slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]    count_q, count_d;
  logic               push, pop;

  assign push_ready_o = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/aes_back.sv -----
// back end: coefficient registers, per environment stores and the arithmetic pipeline
module aes_back import aes_pkg::*; #(
  parameter int ENVS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [COEF_W-1:0]        cfg_data_i,
  input  logic                     head_valid_i,
  input  aes_item_t                head_item_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ENV_W-1:0]         out_env_o,
  output logic signed [DATA_W-1:0] out_advantage_o,
  output logic signed [DATA_W-1:0] out_return_o,
  output logic                     out_saturated_o
);

  localparam int AW = (ENVS > 1) ? $clog2(ENVS) : 1;
  localparam int EXT_W = AW + ENV_W;
  localparam int PROD_W = DATA_W + COEF_W + 1;
  localparam int RND_W = PROD_W + 1;
  localparam int TERM_W = RND_W - COEF_FRAC;
  localparam int ACC_W = TERM_W + 2;

  logic [COEF_W-1:0] discount_q, trace_decay_q, gl_q;
  logic [COEF_W-1:0] cfg_clamped;
  logic [2*COEF_W-1:0] gl_full;

  logic signed [DATA_W-1:0] val_mem [ENVS];
  logic signed [DATA_W-1:0] adv_mem [ENVS];
  logic signed [DATA_W-1:0] rd_val_q, rd_adv_q;

  logic                      en, hazard;
  logic                      s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  aes_item_t                 s1_item_q, s2_item_q;
  logic signed [DATA_W-1:0]  next_val, next_adv;
  logic signed [PROD_W-1:0]  p_val_d, p_adv_d, p_val_q, p_adv_q;
  logic signed [DATA_W:0]    base_d, base_q;
  logic signed [RND_W-1:0]   r_val, r_adv;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DATA_W-1:0]  adv_d;
  logic                      clip_a;
  logic                      wr_en;
  logic [EXT_W-1:0]          wr_ext, rd_ext;
  logic [ENV_W-1:0]          s3_env_q, out_env_q;
  logic signed [DATA_W-1:0]  s3_adv_q, s3_value_q, out_adv_q, out_ret_q;
  logic                      s3_clip_q, out_sat_q;
  logic signed [DATA_W:0]    ret_full;
  logic signed [DATA_W-1:0]  ret_d;
  logic                      clip_r;

  // coefficients
  assign cfg_clamped = (cfg_data_i > COEF_ONE) ? COEF_ONE : cfg_data_i;
  assign gl_full = ((2*COEF_W)'(discount_q) * (2*COEF_W)'(trace_decay_q)
                   + (2*COEF_W)'(1 << (COEF_FRAC - 1))) >> COEF_FRAC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discount_q    <= DISCOUNT_RESET;
      trace_decay_q <= TRACE_DECAY_RESET;
      gl_q          <= '0;
    end else begin
      gl_q <= gl_full[COEF_W-1:0];
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DISCOUNT:    discount_q    <= cfg_clamped;
          CFG_TRACE_DECAY: trace_decay_q <= cfg_clamped;
          default: ;
        endcase
      end
    end
  end

  // issue with same environment interlock
  assign en = !out_valid_q || out_ready_i;
  assign hazard = head_item_i.needs_read &&
                  ((s1_valid_q && s1_item_q.in_range && s1_item_q.env == head_item_i.env) ||
                   (s2_valid_q && s2_item_q.in_range && s2_item_q.env == head_item_i.env));
  assign pop_o = head_valid_i && !hazard && en;

  assign rd_ext = EXT_W'(head_item_i.env);
  assign wr_ext = EXT_W'(s2_item_q.env);
  assign wr_en  = en && s2_valid_q && s2_item_q.in_range;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_val_q <= val_mem[rd_ext[AW-1:0]];
      rd_adv_q <= adv_mem[rd_ext[AW-1:0]];
    end
    if (wr_en) begin
      val_mem[wr_ext[AW-1:0]] <= s2_item_q.state_value;
      adv_mem[wr_ext[AW-1:0]] <= adv_d;
    end
  end

  // stage 1: coefficient products
  always_comb begin
    next_val = '0;
    next_adv = '0;
    if (s1_item_q.first) begin
      next_val = s1_item_q.bootstrap_value;
    end else if (s1_item_q.in_range) begin
      next_val = rd_val_q;
      next_adv = rd_adv_q;
    end
    p_val_d = next_val * $signed({1'b0, discount_q});
    p_adv_d = next_adv * $signed({1'b0, gl_q});
    base_d  = (DATA_W+1)'(s1_item_q.reward) - (DATA_W+1)'(s1_item_q.state_value);
  end

  // stage 2: advantage, store update
  always_comb begin
    r_val = RND_W'(p_val_q) + RND_W'(1 << (COEF_FRAC - 1));
    r_adv = RND_W'(p_adv_q) + RND_W'(1 << (COEF_FRAC - 1));
    acc   = ACC_W'(base_q);
    if (!s2_item_q.done) begin
      acc = acc + ACC_W'($signed(r_val[RND_W-1:COEF_FRAC]))
                + ACC_W'($signed(r_adv[RND_W-1:COEF_FRAC]));
    end
    clip_a = 1'b0;
    adv_d  = acc[DATA_W-1:0];
    if (acc > ACC_W'(DATA_MAX)) begin
      adv_d  = DATA_MAX;
      clip_a = 1'b1;
    end else if (acc < ACC_W'(DATA_MIN)) begin
      adv_d  = DATA_MIN;
      clip_a = 1'b1;
    end
  end

  // stage 3: return
  always_comb begin
    ret_full = (DATA_W+1)'(s3_adv_q) + (DATA_W+1)'(s3_value_q);
    ret_d    = ret_full[DATA_W-1:0];
    clip_r   = s3_clip_q;
    if (ret_full > (DATA_W+1)'(DATA_MAX)) begin
      ret_d  = DATA_MAX;
      clip_r = 1'b1;
    end else if (ret_full < (DATA_W+1)'(DATA_MIN)) begin
      ret_d  = DATA_MIN;
      clip_r = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_item_q  <= head_item_i;
      s2_item_q  <= s1_item_q;
      p_val_q    <= p_val_d;
      p_adv_q    <= p_adv_d;
      base_q     <= base_d;
      s3_env_q   <= s2_item_q.env;
      s3_adv_q   <= adv_d;
      s3_value_q <= s2_item_q.state_value;
      s3_clip_q  <= clip_a;
      out_env_q  <= s3_env_q;
      out_adv_q  <= s3_adv_q;
      out_ret_q  <= ret_d;
      out_sat_q  <= clip_r;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_env_o       = out_env_q;
  assign out_advantage_o = out_adv_q;
  assign out_return_o    = out_ret_q;
  assign out_saturated_o = out_sat_q;

`ifndef SYNTHESIS
  a_no_read_during_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_item_i.needs_read && wr_en |-> head_item_i.env != s2_item_q.env)
    else $error("store read issued for an entry being written");

  a_coef_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discount_q <= COEF_ONE && trace_decay_q <= COEF_ONE && gl_q <= COEF_ONE)
    else $error("coefficient above one");

  a_no_needless_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && !head_item_i.needs_read && en |-> pop_o)
    else $error("item held back without a store dependency");

  a_write_follows_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> s3_valid_q && s3_env_q == $past(s2_item_q.env))
    else $error("store write not matched by a stage 3 item");
`endif

endmodule

// ----- rtl/advantage_estimation_step_core.sv -----
// top level of the generalized advantage estimation step core
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid_i/tready_o     tdata, tlast = done, tuser = first
//   m_axis    out        m_axis_tvalid_o/tready_i     tdata, tuser = saturated
//   cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// one item per cycle sustained while no result stall or same environment interlock holds it back
// an item that reads the stores waits in the queue while an earlier item of the same
// environment is in the two stages before the store write
// result stalls freeze the back pipeline; the four entry queue keeps the input side open
// reset clears control state and loads the default coefficients; store contents are undefined until written
module advantage_estimation_step_core import aes_pkg::*; #(
  parameter int ENVS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // env_index, reward, state_value, bootstrap_value, zero pad
  input  logic [103:0]         s_axis_tdata_i,
  input  logic                 s_axis_tlast_i,
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // out_env_index, advantage, return_value, zero pad
  output logic [71:0]          m_axis_tdata_o,
  output logic                 m_axis_tuser_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  logic                     push_valid, push_ready, head_valid, pop;
  aes_item_t                push_item, head_item;
  logic [ENV_W-1:0]         out_env;
  logic signed [DATA_W-1:0] out_adv, out_ret;

  assign cfg_ready_o = 1'b1;

  aes_front #(.ENVS(ENVS)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid_i),
    .in_ready_o        (s_axis_tready_o),
    .env_i             (s_axis_tdata_i[5:0]),
    .reward_i          (s_axis_tdata_i[37:6]),
    .state_value_i     (s_axis_tdata_i[69:38]),
    .done_i            (s_axis_tlast_i),
    .first_i           (s_axis_tuser_i),
    .bootstrap_value_i (s_axis_tdata_i[101:70]),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_item_o       (push_item)
  );

  aes_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .pop_item_o   (head_item)
  );

  aes_back #(.ENVS(ENVS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .head_valid_i    (head_valid),
    .head_item_i     (head_item),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_env_o       (out_env),
    .out_advantage_o (out_adv),
    .out_return_o    (out_ret),
    .out_saturated_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, out_ret, out_adv, out_env};

endmodule
